// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tag store checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/fals_pkg.sv -----
// ----------------------------------------------------------------------------
// Tag store package
// Widths, operation codes, controller states and the structs that travel
// between the search cells and the controller.
// ----------------------------------------------------------------------------
package fals_pkg;

    localparam int OP_W          = 2;
    localparam int TAG_W         = 64;
    localparam int TIME_W        = 64;
    localparam int SLOT_W        = 6;
    localparam int NUM_LINES_DEF = 64;

    // Operation codes carried by an input word.
    typedef enum logic [OP_W-1:0] {
        OP_PROBE  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_INSERT = 2'd2
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PEND
    } state_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        op_t               op;
        logic [TAG_W-1:0]  addr;
        logic [TIME_W-1:0] now;
        logic              hit;
        logic [TIME_W-1:0] best_age;
    } tok_t;

    // Write-back command broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } wr_t;

endpackage

// ----- rtl/core/fals_if.sv -----
// ----------------------------------------------------------------------------
// Tag store channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------

// Request channel: operation, line address and time stamp.
interface fals_req_if import fals_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TAG_W-1:0]  addr;
    logic [TIME_W-1:0] now;

    modport source (output valid, output operation, output addr, output now, input ready);
    modport sink   (input valid, input operation, input addr, input now, output ready);
endinterface

// Response channel: hit flag, line contents and slot.
interface fals_rsp_if import fals_pkg::*;;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [TAG_W-1:0]  line_tag;
    logic [TIME_W-1:0] line_last_used;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output hit, output line_tag, output line_last_used,
                    output slot, input ready);
    modport sink   (input valid, input hit, input line_tag, input line_last_used,
                    input slot, output ready);
endinterface

// ----- rtl/core/fals_cell.sv -----
// ----------------------------------------------------------------------------
// Tag store cell
// Holds one line (tag and last-used time), updates the passing search token
// with its match and age, and takes broadcast write-backs aimed at its slot.
// ----------------------------------------------------------------------------
module fals_cell import fals_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int CELL_INDEX = 0
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_vld,
    input  tok_t                                  in_tok,
    input  logic [((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1)-1:0] in_hit_idx,
    input  logic [((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1)-1:0] in_best_idx,
    input  logic [$clog2(NUM_LINES + 1)-1:0]      count,
    input  wr_t                                   wr,
    input  logic [((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1)-1:0] wr_idx,
    output logic                                  out_vld,
    output tok_t                                  out_tok,
    output logic [((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1)-1:0] out_hit_idx,
    output logic [((NUM_LINES > 1) ? $clog2(NUM_LINES) : 1)-1:0] out_best_idx
);

    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int CNT_W = $clog2(NUM_LINES + 1);

    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic              vld_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  hit_idx_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic              filled;
    logic              match;
    logic [TIME_W-1:0] age;

    // Slots fill in order, so this slot is filled once the count passes it.
    assign filled = CNT_W'(CELL_INDEX) < count;
    assign match  = filled && (tag_reg == in_tok.addr);
    assign age    = in_tok.now - stamp_reg;

    // Fold this slot into the token: first match wins, oldest age wins.
    always_comb
    begin
        tok_next      = in_tok;
        hit_idx_next  = in_hit_idx;
        best_idx_next = in_best_idx;
        if (!in_tok.hit && match)
        begin
            tok_next.hit = 1'b1;
            hit_idx_next = IDX_W'(CELL_INDEX);
        end
        if ((CELL_INDEX == 0) || (age > in_tok.best_age))
        begin
            tok_next.best_age = age;
            best_idx_next     = IDX_W'(CELL_INDEX);
        end
    end

    // Token valid moves one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    // Token payload and line contents.
    always_ff @(posedge clk)
    begin
        tok_reg      <= tok_next;
        hit_idx_reg  <= hit_idx_next;
        best_idx_reg <= best_idx_next;
        if (wr.en && (wr_idx == IDX_W'(CELL_INDEX)))
        begin
            tag_reg   <= wr.tag;
            stamp_reg <= wr.stamp;
        end
    end

    assign out_vld      = vld_reg;
    assign out_tok      = tok_reg;
    assign out_hit_idx  = hit_idx_reg;
    assign out_best_idx = best_idx_reg;

endmodule

// ----- rtl/core/fully_assoc_lru_tag_store.sv -----
// A request word is taken only while the block is idle; its search token then walks the
// chain of NUM_LINES cells, one cell per cycle, collecting the first match and the oldest age.
// When the token leaves the chain the result is held as a pending response, then moved to the
// response register once that is free; the next request word is taken only after that move.
// Reset clears the fill count, the controller and the response valid; lines are unset until
// written, and no clearing pass runs.
// ----------------------------------------------------------------------------
// Fully associative LRU tag store
// Top level: search chain of line cells, write-back controller, response
// register.
// ----------------------------------------------------------------------------
module fully_assoc_lru_tag_store import fals_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    fals_req_if.sink   req,
    fals_rsp_if.source rsp
);

    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int CNT_W = $clog2(NUM_LINES + 1);

    state_t            state_reg;
    state_t            state_next;
    logic              req_ready;
    logic              req_acc;
    logic              capture;
    logic              load;

    logic              chain_vld      [NUM_LINES+1];
    tok_t              chain_tok      [NUM_LINES+1];
    logic [IDX_W-1:0]  chain_hit_idx  [NUM_LINES+1];
    logic [IDX_W-1:0]  chain_best_idx [NUM_LINES+1];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    wr_t               wr;
    logic [IDX_W-1:0]  wr_idx;
    tok_t              end_tok;
    logic              room;
    logic [IDX_W-1:0]  where;

    logic              pend_hit_reg;
    logic              pend_hit_next;
    logic [TAG_W-1:0]  pend_tag_reg;
    logic [TAG_W-1:0]  pend_tag_next;
    logic [TIME_W-1:0] pend_stamp_reg;
    logic [TIME_W-1:0] pend_stamp_next;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [SLOT_W-1:0] pend_slot_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_hit_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [TIME_W-1:0] out_stamp_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    assign req_acc   = req.valid && req_ready;
    assign req.ready = req_ready;

    // Head of the chain is fed straight from the request word.
    assign chain_vld[0]      = req_acc;
    assign chain_tok[0]      = '{op: op_t'(req.operation), addr: req.addr, now: req.now,
                                 hit: 1'b0, best_age: '0};
    assign chain_hit_idx[0]  = '0;
    assign chain_best_idx[0] = '0;

    // Row of line cells.
    for (genvar i = 0; i < NUM_LINES; i++)
    begin : g_cell
        fals_cell #(
            .NUM_LINES  (NUM_LINES),
            .CELL_INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_vld       (chain_vld[i]),
            .in_tok       (chain_tok[i]),
            .in_hit_idx   (chain_hit_idx[i]),
            .in_best_idx  (chain_best_idx[i]),
            .count        (count_reg),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .out_vld      (chain_vld[i+1]),
            .out_tok      (chain_tok[i+1]),
            .out_hit_idx  (chain_hit_idx[i+1]),
            .out_best_idx (chain_best_idx[i+1])
        );
    end

    // Controller state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Controller next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        capture    = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_vld[NUM_LINES])
                begin
                    capture    = 1'b1;
                    state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Resolve the finished search into a write-back and a response.
    assign end_tok = chain_tok[NUM_LINES];
    assign room    = count_reg < CNT_W'(NUM_LINES);
    assign where   = room ? count_reg[IDX_W-1:0] : chain_best_idx[NUM_LINES];

    always_comb
    begin
        wr              = '{en: 1'b0, tag: end_tok.addr, stamp: end_tok.now};
        wr_idx          = chain_hit_idx[NUM_LINES];
        count_next      = count_reg;
        pend_hit_next   = 1'b0;
        pend_tag_next   = '0;
        pend_stamp_next = '0;
        pend_slot_next  = '0;
        unique case (end_tok.op)
            OP_PROBE:
            begin
                pend_hit_next = end_tok.hit;
            end
            OP_LOOKUP:
            begin
                if (end_tok.hit)
                begin
                    wr.en           = capture;
                    pend_hit_next   = 1'b1;
                    pend_tag_next   = end_tok.addr;
                    pend_stamp_next = end_tok.now;
                    pend_slot_next  = SLOT_W'(chain_hit_idx[NUM_LINES]);
                end
            end
            OP_INSERT:
            begin
                wr.en          = capture;
                wr_idx         = where;
                pend_slot_next = SLOT_W'(where);
                if (capture && room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                pend_hit_next = 1'b0;
            end
        endcase
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Pending response, held until the response register is free.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            pend_hit_reg   <= pend_hit_next;
            pend_tag_reg   <= pend_tag_next;
            pend_stamp_reg <= pend_stamp_next;
            pend_slot_reg  <= pend_slot_next;
        end
    end

    // Response register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Response register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_hit_reg   <= pend_hit_reg;
            out_tag_reg   <= pend_tag_reg;
            out_stamp_reg <= pend_stamp_reg;
            out_slot_reg  <= pend_slot_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.line_tag       = out_tag_reg;
    assign rsp.line_last_used = out_stamp_reg;
    assign rsp.slot           = out_slot_reg;

endmodule

// ----- rtl/core/fals_checker.sv -----
// ----------------------------------------------------------------------------
// Tag store checker
// Port-level checks on the request and response channels, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fals_checker import fals_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_hit,
    input logic [TAG_W-1:0]  rsp_line_tag,
    input logic [TIME_W-1:0] rsp_line_last_used,
    input logic [SLOT_W-1:0] rsp_slot
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;

    assign in_acc  = req_valid && req_ready;
    assign out_acc = rsp_valid && rsp_ready;

    // Count of request words whose response word has not been taken.
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_acc && !out_acc)
        begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 2'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A stalled response word holds still.
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_hit) && $stable(rsp_line_tag) &&
        $stable(rsp_line_last_used) && $stable(rsp_slot))

    // One request word at a time enters the search chain.
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !req_ready)

    // No response word without a request word behind it.
    `ASSERT_IMPL(a_no_orphan, clk, rst_n, rsp_valid, outstanding_reg != 2'd0)

    // A miss carries no line contents.
    `ASSERT_IMPL(a_miss_zero, clk, rst_n, rsp_valid && !rsp_hit,
        rsp_line_tag == '0 && rsp_line_last_used == '0)

endmodule

bind fully_assoc_lru_tag_store fals_checker u_fals_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_hit            (rsp.hit),
    .rsp_line_tag       (rsp.line_tag),
    .rsp_line_last_used (rsp.line_last_used),
    .rsp_slot           (rsp.slot)
);
